// ===== hw/rtl/whp_pkg.sv =====
`timescale 1ns / 1ps

package whp_pkg;

  // one byte of the file stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one parse result per file
  typedef struct packed {
    logic [2:0]  error_code;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] sample_count;
  } out_item_t;

  // four-character codes, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE      = 32'd16;
  localparam logic [31:0] TAG_BYTES     = 32'd4;
  localparam int          PRELUDE_BYTES = 12;
  localparam int          HDR_BYTES     = 8;

  // result codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_SHORT      = 3'd1;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
  localparam logic [2:0] ERR_NOT_WAVE   = 3'd3;
  localparam logic [2:0] ERR_FMT_SIZE   = 3'd4;
  localparam logic [2:0] ERR_NOT_PCM    = 3'd5;
  localparam logic [2:0] ERR_MISSING    = 3'd6;
  localparam logic [2:0] ERR_FIELDS     = 3'd7;

  // divider sizes: payload length over channels times bytes per sample
  localparam int DIVIDEND_WIDTH = 32;
  localparam int DIVISOR_WIDTH  = 29;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       prelude;
    logic       shift;
    logic       cnt_dec;
    logic       hdr_start;
    logic       fmt_start;
    logic       skip_start;
    logic       fmt_byte;
    logic       data_found;
    logic       fmt_found;
    logic       err_set;
    logic [2:0] err_code;
    logic       final_load;
    logic       div_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       riff_mis;
    logic       wave_mis;
    logic       prelude_last;
    logic       cnt_last;
    logic       tag_fmt;
    logic       tag_data;
    logic       size_over;
    logic       size_16;
    logic       size_zero;
    logic       hdr_end;
    logic       hdr_over;
    logic       found_fmt;
    logic       found_data;
    logic       pcm_bad;
    logic [2:0] final_code;
    logic       div_done;
  } status_t;

endpackage

// ===== hw/rtl/wave_header_parser.sv =====
`timescale 1ns / 1ps

// RIFF/WAVE header parser.
// Input channel (in_valid / in_stall / in_payload): the file one byte per
// transaction, in file order, with last_byte set on the final byte. The byte
// after a marked one begins a new file.
// Result channel (out_valid / out_stall / out_payload): one transaction per
// file carrying the result code, the fmt fields, the data chunk offset and
// length, and the sample count.
// Throughput: one byte per cycle while a file streams in and no result is
// held in the output register. After the marked byte the input is stalled
// while the result is formed: the finalise state for an error result, and
// for a good one also the 32-step shift-subtract divider that forms the
// sample count.
// A finished result sits in the output register; while it is held there by
// out_stall the input is stalled as well (in_stall follows out_stall while
// the output register is full).
// Reset (rst_n low at a clock edge) empties the output register and returns
// the parser to the start of a file.

module wave_header_parser #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  whp_pkg::in_item_t   in_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output whp_pkg::out_item_t  out_payload
);

  whp_pkg::cmd_t    cmd;
  whp_pkg::status_t status;

  // parse sequencing and output handshake
  whp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // counters, field registers, bounds checks and divider
  whp_dpath #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .status      (status),
    .out_payload (out_payload)
  );

endmodule

// ===== hw/rtl/whp_div.sv =====
`timescale 1ns / 1ps

module whp_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [whp_pkg::DIVIDEND_WIDTH-1:0]  dividend,
  input  logic [whp_pkg::DIVISOR_WIDTH-1:0]   divisor,
  output logic [whp_pkg::DIVIDEND_WIDTH-1:0]  quotient,
  output logic                                done
);

  localparam int QW = whp_pkg::DIVIDEND_WIDTH;
  localparam int DW = whp_pkg::DIVISOR_WIDTH;
  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] count_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // one restoring step per cycle
  assign trial = {rem_r, quo_r[QW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= busy_r && (count_r == '0);
      if (start) begin
        busy_r  <= 1'b1;
        count_r <= CW'(QW - 1);
      end else if (busy_r) begin
        if (count_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          count_r <= count_r - CW'(1);
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== hw/rtl/whp_dpath.sv =====
`timescale 1ns / 1ps

module whp_dpath #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  whp_pkg::in_item_t   in_payload,
  input  whp_pkg::cmd_t       cmd,
  output whp_pkg::status_t    status,
  output whp_pkg::out_item_t  out_payload
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [4:0]                FMT_SIZE_5 = 5'(whp_pkg::FMT_SIZE);

  logic [POSITION_WIDTH-1:0] pos_r;
  logic [POSITION_WIDTH-1:0] pos_nxt;
  logic [POSITION_WIDTH:0]   next_pos;
  logic [POSITION_WIDTH:0]   len_r;
  logic [32:0]               len_ext;
  logic [33:0]               next_ext;
  logic [31:0]               field_r;
  logic [31:0]               field_shifted;
  logic [31:0]               decl_r;
  logic [31:0]               chunk_r;
  logic [15:0]               chan_r;
  logic [31:0]               rate_r;
  logic [15:0]               bits_r;
  logic [31:0]               offs_r;
  logic [31:0]               plen_r;
  logic [1:0]                found_r;
  logic [2:0]                ferr_r;
  logic [32:0]               riff_end;
  logic [1:0]                lane;
  logic [7:0]                riff_byte;
  logic [7:0]                wave_byte;
  logic [3:0]                fmt_idx;
  logic [2:0]                final_code;
  logic [7:0]                din;
  logic                      in_lenfield;
  logic [whp_pkg::DIVISOR_WIDTH-1:0]  prod_r;
  logic [whp_pkg::DIVIDEND_WIDTH-1:0] quo;
  logic                      div_done;
  whp_pkg::out_item_t        out_r;

  assign din = in_payload.data_byte;

  // byte position, saturating
  assign pos_nxt  = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_WIDTH'(1);
  assign next_pos = {1'b0, pos_r} + (POSITION_WIDTH + 1)'(1);
  assign next_ext = 34'(next_pos);
  assign len_ext  = 33'(len_r);

  // prelude byte checks
  assign lane        = pos_r[1:0];
  assign riff_byte   = 8'(whp_pkg::TAG_RIFF >> {lane, 3'b000});
  assign wave_byte   = 8'(whp_pkg::TAG_WAVE >> {lane, 3'b000});
  assign in_lenfield = (pos_r >= POSITION_WIDTH'(4)) && (pos_r < POSITION_WIDTH'(8));

  // chunk field assembly and bounds
  assign field_shifted = {din, field_r[31:8]};
  assign riff_end      = {1'b0, decl_r} + 33'(whp_pkg::HDR_BYTES);
  assign fmt_idx       = 4'(FMT_SIZE_5 - chunk_r[4:0]);

  // result code, evaluated on the cycle after the final byte
  always_comb begin
    if (len_ext < 33'(whp_pkg::PRELUDE_BYTES) || ferr_r == whp_pkg::ERR_SHORT) begin
      final_code = whp_pkg::ERR_SHORT;
    end else if (riff_end > len_ext) begin
      final_code = whp_pkg::ERR_INCOMPLETE;
    end else if (ferr_r != whp_pkg::ERR_OK) begin
      final_code = ferr_r;
    end else if (found_r != 2'b11) begin
      final_code = whp_pkg::ERR_MISSING;
    end else if (chan_r == 16'd0 || bits_r < 16'd8) begin
      final_code = whp_pkg::ERR_FIELDS;
    end else begin
      final_code = whp_pkg::ERR_OK;
    end
  end

  // status towards the controller
  always_comb begin
    status.riff_mis     = (pos_r < POSITION_WIDTH'(4)) && (din != riff_byte);
    status.wave_mis     = (pos_r >= POSITION_WIDTH'(8))
                          && (pos_r < POSITION_WIDTH'(whp_pkg::PRELUDE_BYTES))
                          && (din != wave_byte);
    status.prelude_last = pos_r == POSITION_WIDTH'(whp_pkg::PRELUDE_BYTES - 1);
    status.cnt_last     = chunk_r == 32'd1;
    status.tag_fmt      = field_shifted == whp_pkg::TAG_FMT;
    status.tag_data     = field_shifted == whp_pkg::TAG_DATA;
    status.size_over    = (next_ext + {2'b00, field_shifted}) > {1'b0, riff_end};
    status.size_16      = field_shifted == whp_pkg::FMT_SIZE;
    status.size_zero    = field_shifted == 32'd0;
    status.hdr_end      = next_ext >= {1'b0, riff_end};
    status.hdr_over     = (next_ext + 34'(whp_pkg::HDR_BYTES)) > {1'b0, riff_end};
    status.found_fmt    = found_r[0];
    status.found_data   = found_r[1];
    status.pcm_bad      = (fmt_idx == 4'd1) && ({din, field_r[7:0]} != 16'd1);
    status.final_code   = final_code;
    status.div_done     = div_done;
  end

  // parse control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      found_r <= '0;
      ferr_r  <= whp_pkg::ERR_OK;
    end else if (cmd.final_load) begin
      pos_r   <= '0;
      found_r <= '0;
      ferr_r  <= whp_pkg::ERR_OK;
    end else begin
      if (cmd.take) begin
        pos_r <= pos_nxt;
      end
      found_r <= found_r | {cmd.data_found, cmd.fmt_found};
      if (cmd.err_set && ferr_r == whp_pkg::ERR_OK) begin
        ferr_r <= cmd.err_code;
      end
    end
  end

  // field shifter, chunk counter and held fields
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len_r <= next_pos;
    end
    if (cmd.prelude && in_lenfield) begin
      decl_r[{lane, 3'b000} +: 8] <= din;
    end

    if (cmd.hdr_start) begin
      chunk_r <= whp_pkg::TAG_BYTES;
    end else if (cmd.fmt_start) begin
      chunk_r <= whp_pkg::FMT_SIZE;
    end else if (cmd.skip_start) begin
      chunk_r <= field_shifted;
    end else if (cmd.cnt_dec) begin
      chunk_r <= chunk_r - 32'd1;
    end

    if (cmd.hdr_start || cmd.fmt_start) begin
      field_r <= '0;
    end else if (cmd.fmt_byte && fmt_idx == 4'd0) begin
      field_r <= {24'd0, din};
    end else if (cmd.shift) begin
      field_r <= field_shifted;
    end

    if (cmd.fmt_byte) begin
      case (fmt_idx)
        4'd2:                   chan_r[7:0]  <= din;
        4'd3:                   chan_r[15:8] <= din;
        4'd4, 4'd5, 4'd6, 4'd7: rate_r[{fmt_idx[1:0], 3'b000} +: 8] <= din;
        4'd14:                  bits_r[7:0]  <= din;
        4'd15:                  bits_r[15:8] <= din;
        default: ;
      endcase
    end

    if (cmd.data_found) begin
      offs_r <= next_ext[31:0];
      plen_r <= field_shifted;
    end
  end

  // result register and divisor product
  always_ff @(posedge clk) begin
    if (cmd.final_load) begin
      out_r.error_code <= final_code;
      if (final_code == whp_pkg::ERR_OK || final_code == whp_pkg::ERR_FIELDS) begin
        out_r.channel_count   <= chan_r;
        out_r.sample_rate     <= rate_r;
        out_r.bits_per_sample <= bits_r;
        out_r.payload_offset  <= offs_r;
        out_r.payload_length  <= plen_r;
      end else begin
        out_r.channel_count   <= '0;
        out_r.sample_rate     <= '0;
        out_r.bits_per_sample <= '0;
        out_r.payload_offset  <= '0;
        out_r.payload_length  <= '0;
      end
      out_r.sample_count <= '0;
      prod_r <= {13'd0, chan_r} * {16'd0, bits_r[15:3]};
    end else if (div_done) begin
      out_r.sample_count <= quo;
    end
  end

  whp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (out_r.payload_length),
    .divisor  (prod_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign out_payload = out_r;

endmodule

// ===== hw/rtl/whp_ctrl.sv =====
`timescale 1ns / 1ps

module whp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  whp_pkg::in_item_t  in_payload,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  whp_pkg::status_t   status,
  output whp_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    PH_PRELUDE,
    PH_TAG,
    PH_SIZE_OTHER,
    PH_SIZE_FMT,
    PH_SIZE_DATA,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    FL_RUN,
    FL_FINAL,
    FL_START,
    FL_DIV
  } flow_t;

  phase_t phase_r, phase_nxt;
  flow_t  flow_r, flow_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   hdr_go;
  logic   hdr_both;

  assign in_stall  = (flow_r != FL_RUN) || (out_valid_r && out_stall);
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    cmd           = '0;
    phase_nxt     = phase_r;
    flow_nxt      = flow_r;
    out_valid_nxt = out_valid_r;
    hdr_go        = 1'b0;
    hdr_both      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (flow_r)
      FL_RUN: begin
        if (take) begin
          cmd.take = 1'b1;
          if (in_payload.last_byte) begin
            flow_nxt = FL_FINAL;
          end

          unique case (phase_r) inside
            PH_PRELUDE: begin
              cmd.prelude = 1'b1;
              if (status.riff_mis) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = whp_pkg::ERR_SHORT;
              end else if (status.wave_mis) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = whp_pkg::ERR_NOT_WAVE;
              end else if (status.prelude_last && status.hdr_over) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = whp_pkg::ERR_INCOMPLETE;
              end
              // first chunk header is never skipped: it is read, or flagged incomplete if it runs past the riff end
              if (status.prelude_last) begin
                if (status.hdr_over) begin
                  phase_nxt = PH_DONE;
                end else begin
                  cmd.hdr_start = 1'b1;
                  phase_nxt     = PH_TAG;
                end
              end
            end

            PH_TAG: begin
              cmd.shift   = 1'b1;
              cmd.cnt_dec = 1'b1;
              if (status.cnt_last) begin
                cmd.hdr_start = 1'b1;
                if (status.tag_fmt) begin
                  phase_nxt = PH_SIZE_FMT;
                end else if (status.tag_data) begin
                  phase_nxt = PH_SIZE_DATA;
                end else begin
                  phase_nxt = PH_SIZE_OTHER;
                end
              end
            end

            PH_SIZE_OTHER, PH_SIZE_FMT, PH_SIZE_DATA: begin
              cmd.shift   = 1'b1;
              cmd.cnt_dec = 1'b1;
              if (status.cnt_last) begin
                if (status.size_over) begin
                  cmd.err_set  = 1'b1;
                  cmd.err_code = whp_pkg::ERR_INCOMPLETE;
                  phase_nxt    = PH_DONE;
                end else if (phase_r == PH_SIZE_FMT) begin
                  if (!status.size_16) begin
                    cmd.err_set  = 1'b1;
                    cmd.err_code = whp_pkg::ERR_FMT_SIZE;
                    phase_nxt    = PH_DONE;
                  end else begin
                    cmd.fmt_start = 1'b1;
                    phase_nxt     = PH_FMT;
                  end
                end else begin
                  cmd.data_found = phase_r == PH_SIZE_DATA;
                  if (status.size_zero) begin
                    hdr_go   = 1'b1;
                    hdr_both = status.found_fmt
                               && (status.found_data || phase_r == PH_SIZE_DATA);
                  end else begin
                    cmd.skip_start = 1'b1;
                    phase_nxt      = PH_SKIP;
                  end
                end
              end
            end

            PH_FMT: begin
              cmd.fmt_byte = 1'b1;
              if (status.pcm_bad) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = whp_pkg::ERR_NOT_PCM;
                phase_nxt    = PH_DONE;
              end else begin
                cmd.cnt_dec = 1'b1;
                if (status.cnt_last) begin
                  cmd.fmt_found = 1'b1;
                  hdr_go        = 1'b1;
                  hdr_both      = status.found_data;
                end
              end
            end

            PH_SKIP: begin
              cmd.cnt_dec = 1'b1;
              if (status.cnt_last) begin
                hdr_go   = 1'b1;
                hdr_both = status.found_fmt && status.found_data;
              end
            end

            PH_DONE: ;
          endcase

          // next chunk header: stop, fail or start reading its tag
          if (hdr_go) begin
            if (hdr_both || status.hdr_end) begin
              phase_nxt = PH_DONE;
            end else if (status.hdr_over) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = whp_pkg::ERR_INCOMPLETE;
              phase_nxt    = PH_DONE;
            end else begin
              cmd.hdr_start = 1'b1;
              phase_nxt     = PH_TAG;
            end
          end
        end
      end

      FL_FINAL: begin
        cmd.final_load = 1'b1;
        phase_nxt      = PH_PRELUDE;
        if (status.final_code == whp_pkg::ERR_OK) begin
          flow_nxt = FL_START;
        end else begin
          out_valid_nxt = 1'b1;
          flow_nxt      = FL_RUN;
        end
      end

      FL_START: begin
        cmd.div_start = 1'b1;
        flow_nxt      = FL_DIV;
      end

      FL_DIV: begin
        if (status.div_done) begin
          out_valid_nxt = 1'b1;
          flow_nxt      = FL_RUN;
        end
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PRELUDE;
      flow_r      <= FL_RUN;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      flow_r      <= flow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result is only loaded into an empty output register
  a_final_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    flow_r == FL_FINAL |-> !out_valid_r)
    else $error("result finalised while output register still full");

  // finalise state is left again in the next cycle
  a_final_once: assert property (@(posedge clk) disable iff (!rst_n)
    flow_r == FL_FINAL |=> flow_r != FL_FINAL)
    else $error("finalise state held for more than one cycle");

  // next file starts from the prelude
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    flow_r == FL_FINAL |=> phase_r == PH_PRELUDE)
    else $error("parser not restarted after result");

  // divider completes only while waited for
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> flow_r == FL_DIV)
    else $error("divider finished outside the divide state");

endmodule

// ===== test/wave_header_parser_tb.sv =====
`timescale 1ns / 1ps

module wave_header_parser_tb;

  // where the chunk walk stands within the file
  typedef enum logic [3:0] {
    WALK_PRELUDE,
    WALK_TAG,
    WALK_SIZE_OTHER,
    WALK_SIZE_FMT,
    WALK_SIZE_DATA,
    WALK_FMT_BODY,
    WALK_SKIP,
    WALK_DONE
  } walk_phase_t;

  localparam bit [15:0] FORMAT_PCM   = 16'd1;
  localparam bit [15:0] FORMAT_FLOAT = 16'd3;

  // header walk predictor and store of expected per-file results
  class header_scoreboard;
    bit [31:0]   position;
    walk_phase_t phase;
    bit [31:0]   shift_word;
    bit [31:0]   riff_length;
    bit [31:0]   remaining;
    bit [15:0]   channels;
    bit [31:0]   rate;
    bit [15:0]   bits;
    bit [31:0]   offset;
    bit [31:0]   length;
    bit [1:0]    found;
    bit [2:0]    first_err;
    whp_pkg::out_item_t expected_results[$];
    int          failures;

    function new();
      failures = 0;
      clear_file();
    endfunction

    function void clear_file();
      position    = '0;
      phase       = WALK_PRELUDE;
      shift_word  = '0;
      riff_length = '0;
      remaining   = '0;
      channels    = '0;
      rate        = '0;
      bits        = '0;
      offset      = '0;
      length      = '0;
      found       = '0;
      first_err   = whp_pkg::ERR_OK;
    endfunction

    function longint unsigned riff_end();
      return 64'(riff_length) + 64'd8;
    endfunction

    function void set_error(bit [2:0] code);
      if (first_err == whp_pkg::ERR_OK) first_err = code;
      phase = WALK_DONE;
    endfunction

    // decide what happens at a chunk header starting at hdr_pos
    function void open_header(longint unsigned hdr_pos, bit first);
      if (!first && (found == 2'b11 || hdr_pos >= riff_end())) begin
        phase = WALK_DONE;
        return;
      end
      if (hdr_pos + 64'(whp_pkg::HDR_BYTES) > riff_end()) begin
        set_error(whp_pkg::ERR_INCOMPLETE);
        return;
      end
      phase      = WALK_TAG;
      remaining  = whp_pkg::TAG_BYTES;
      shift_word = '0;
    endfunction

    function void walk_byte(longint unsigned idx, bit [7:0] b);
      longint unsigned next_pos;
      int pi;
      int k;
      next_pos = idx + 1;
      case (phase)
        WALK_PRELUDE: begin
          pi = int'(idx);
          if (pi < 4) begin
            if (b != 8'(whp_pkg::TAG_RIFF >> (8 * pi))) set_error(whp_pkg::ERR_SHORT);
          end else if (pi < 8) begin
            riff_length = riff_length | (32'(b) << (8 * (pi - 4)));
          end else if (pi < whp_pkg::PRELUDE_BYTES) begin
            if (b != 8'(whp_pkg::TAG_WAVE >> (8 * (pi - 8)))
                && first_err == whp_pkg::ERR_OK) begin
              first_err = whp_pkg::ERR_NOT_WAVE;
            end
          end
          // a bad riff tag does not cut the prelude short
          if (phase == WALK_DONE && next_pos < whp_pkg::PRELUDE_BYTES) phase = WALK_PRELUDE;
          if (next_pos == whp_pkg::PRELUDE_BYTES) begin
            open_header(64'(whp_pkg::PRELUDE_BYTES), 1'b1);
          end
        end
        WALK_TAG: begin
          shift_word = {b, shift_word[31:8]};
          remaining--;
          if (remaining == 0) begin
            if (shift_word == whp_pkg::TAG_FMT) phase = WALK_SIZE_FMT;
            else if (shift_word == whp_pkg::TAG_DATA) phase = WALK_SIZE_DATA;
            else phase = WALK_SIZE_OTHER;
            remaining  = whp_pkg::TAG_BYTES;
            shift_word = '0;
          end
        end
        WALK_SIZE_OTHER, WALK_SIZE_FMT, WALK_SIZE_DATA: begin
          shift_word = {b, shift_word[31:8]};
          remaining--;
          if (remaining == 0) begin
            if (next_pos + 64'(shift_word) > riff_end()) begin
              set_error(whp_pkg::ERR_INCOMPLETE);
            end else if (phase == WALK_SIZE_FMT) begin
              if (shift_word != whp_pkg::FMT_SIZE) begin
                set_error(whp_pkg::ERR_FMT_SIZE);
              end else begin
                remaining  = whp_pkg::FMT_SIZE;
                shift_word = '0;
                phase      = WALK_FMT_BODY;
              end
            end else begin
              if (phase == WALK_SIZE_DATA) begin
                offset   = next_pos[31:0];
                length   = shift_word;
                found[1] = 1'b1;
              end
              if (shift_word == 0) begin
                open_header(next_pos, 1'b0);
              end else begin
                remaining = shift_word;
                phase     = WALK_SKIP;
              end
            end
          end
        end
        WALK_FMT_BODY: begin
          k = int'(whp_pkg::FMT_SIZE - remaining);
          if (k == 1 && {b, shift_word[7:0]} != FORMAT_PCM) begin
            set_error(whp_pkg::ERR_NOT_PCM);
          end else begin
            case (k)
              0:       shift_word = 32'(b);
              2:       channels = 16'(b);
              3:       channels[15:8] = b;
              4:       rate = 32'(b);
              5, 6, 7: rate[8*(k-4) +: 8] = b;
              14:      bits = 16'(b);
              15:      bits[15:8] = b;
              default: ;
            endcase
            remaining--;
            if (remaining == 0) begin
              found[0] = 1'b1;
              open_header(next_pos, 1'b0);
            end
          end
        end
        WALK_SKIP: begin
          remaining--;
          if (remaining == 0) open_header(next_pos, 1'b0);
        end
        default: ;
      endcase
    endfunction

    // accepted input transaction: advance the walk, predict on the marked byte
    function void note_byte(whp_pkg::in_item_t item);
      longint unsigned idx;
      longint unsigned len;
      bit [2:0] code;
      whp_pkg::out_item_t res;
      idx = 64'(position);
      walk_byte(idx, item.data_byte);
      if (position != 32'hFFFF_FFFF) position = position + 1;
      if (item.last_byte !== 1'b1) return;
      len = idx + 1;
      if (len < whp_pkg::PRELUDE_BYTES || first_err == whp_pkg::ERR_SHORT) begin
        code = whp_pkg::ERR_SHORT;
      end else if (riff_end() > len) begin
        code = whp_pkg::ERR_INCOMPLETE;
      end else if (first_err != whp_pkg::ERR_OK) begin
        code = first_err;
      end else if (found != 2'b11) begin
        code = whp_pkg::ERR_MISSING;
      end else if (channels == 0 || bits < 8) begin
        code = whp_pkg::ERR_FIELDS;
      end else begin
        code = whp_pkg::ERR_OK;
      end
      res = '0;
      res.error_code = code;
      if (code == whp_pkg::ERR_OK || code == whp_pkg::ERR_FIELDS) begin
        res.channel_count   = channels;
        res.sample_rate     = rate;
        res.bits_per_sample = bits;
        res.payload_offset  = offset;
        res.payload_length  = length;
        if (code == whp_pkg::ERR_OK) begin
          res.sample_count = length / 32'(channels) / 32'(bits >> 3);
        end
      end
      expected_results.push_back(res);
      clear_file();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(whp_pkg::out_item_t got);
      whp_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("result with no file pending: code %0d", got.error_code));
        return;
      end
      want = expected_results.pop_front();
      compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
      compare_field("channel_count", 64'(want.channel_count), 64'(got.channel_count));
      compare_field("sample_rate", 64'(want.sample_rate), 64'(got.sample_rate));
      compare_field("bits_per_sample", 64'(want.bits_per_sample), 64'(got.bits_per_sample));
      compare_field("payload_offset", 64'(want.payload_offset), 64'(got.payload_offset));
      compare_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
      compare_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  whp_pkg::in_item_t  in_payload = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  whp_pkg::out_item_t out_payload;

  header_scoreboard board;
  bit [7:0] file_bytes[$];
  int       bytes_streamed = 0;
  bit       steady = 1'b0;
  int       stall_left = 0;
  int       free_left = 0;

  wave_header_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side back-pressure: short stalls mostly, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      free_left = $urandom_range(0, 30);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: stall_left = 0;
        5, 6, 7:       stall_left = $urandom_range(1, 3);
        8:             stall_left = $urandom_range(4, 12);
        default:       stall_left = $urandom_range(20, 60);
      endcase
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) board.note_byte(in_payload);
      if (out_valid === 1'b1 && !out_stall) board.check_result(out_payload);
    end
  end

  // file building helpers, multi-byte fields little endian
  function automatic void put16(logic [15:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
  endfunction

  function automatic void put32(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function automatic void add_junk(int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void start_file();
    file_bytes.delete();
    put32(whp_pkg::TAG_RIFF);
    put32(32'd0);
    put32(whp_pkg::TAG_WAVE);
  endfunction

  function automatic void set_declared(logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes[4+i] = w[8*i +: 8];
  endfunction

  function automatic void seal_file();
    set_declared(32'(file_bytes.size() - 8));
  endfunction

  function automatic void truncate_file(int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endfunction

  function automatic void add_fmt(logic [15:0] fmt_code, logic [31:0] size, logic [15:0] ch,
                                  logic [31:0] hz, logic [15:0] depth);
    put32(whp_pkg::TAG_FMT);
    put32(size);
    put16(fmt_code);
    put16(ch);
    put32(hz);
    put32($urandom);
    put16(16'($urandom));
    put16(depth);
  endfunction

  function automatic void add_data(int n);
    put32(whp_pkg::TAG_DATA);
    put32(32'(n));
    add_junk(n);
  endfunction

  function automatic void add_unknown(int n);
    logic [31:0] tag;
    tag = $urandom;
    if (tag == whp_pkg::TAG_FMT || tag == whp_pkg::TAG_DATA) tag[0] = ~tag[0];
    put32(tag);
    put32(32'(n));
    add_junk(n);
  endfunction

  function automatic void add_random_fmt();
    logic [15:0] fmt_code;
    logic [31:0] size;
    logic [15:0] ch;
    logic [31:0] hz;
    logic [15:0] depth;
    fmt_code = ($urandom_range(0, 99) < 92) ? FORMAT_PCM : 16'($urandom);
    size     = ($urandom_range(0, 99) < 94) ? whp_pkg::FMT_SIZE : 32'($urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0:       ch = 16'd0;
      1:       ch = 16'($urandom);
      default: ch = 16'($urandom_range(1, 8));
    endcase
    hz = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(8000, 192000)) : 32'($urandom);
    case ($urandom_range(0, 9))
      0:       depth = 16'($urandom_range(0, 7));
      1:       depth = 16'($urandom);
      default: depth = 16'(8 * $urandom_range(1, 4));
    endcase
    add_fmt(fmt_code, size, ch, hz, depth);
  endfunction

  function automatic int pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 24);
    if (r < 96) return $urandom_range(25, 120);
    return $urandom_range(200, 700);
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // one input transaction, returns at the edge that accepts it
  task automatic send_byte(bit [7:0] b, bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= {b, last};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_streamed++;
  endtask

  task automatic send_file();
    steady = ($urandom_range(0, 4) == 0);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // one hand-picked file per error code and corner of the walk
  task automatic directed_files();
    // clean mono 8-bit
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(6);
    seal_file();
    send_file();
    // data before fmt, empty unknown chunk ahead
    start_file();
    add_unknown(0);
    add_data(8);
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd2, 32'd44100, 16'd16);
    seal_file();
    send_file();
    // all-ones fields
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_data(3);
    seal_file();
    send_file();
    // empty data chunk, then bytes past the riff end
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd1, 16'd8);
    add_data(0);
    seal_file();
    add_junk(5);
    send_file();
    // zero channels
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd0, 32'd48000, 16'd16);
    add_data(4);
    seal_file();
    send_file();
    // bit depth below one byte
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd2, 32'd48000, 16'd7);
    add_data(4);
    seal_file();
    send_file();
    // second fmt chunk overrides the first
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd2, 32'd22050, 16'd16);
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd96000, 16'd24);
    add_data(12);
    seal_file();
    send_file();
    // bad riff tag
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(2);
    seal_file();
    file_bytes[0] = 8'h00;
    send_file();
    // single byte, then a file one short of the prelude
    file_bytes.delete();
    file_bytes.push_back(8'hFF);
    send_file();
    start_file();
    seal_file();
    truncate_file(whp_pkg::PRELUDE_BYTES - 1);
    send_file();
    // declared length one past the file
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(4);
    set_declared(32'(file_bytes.size() - 7));
    send_file();
    // prelude only: riff end at and before the first header
    start_file();
    seal_file();
    send_file();
    start_file();
    set_declared(32'd0);
    send_file();
    // bad wave tag
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(4);
    seal_file();
    file_bytes[9] = 8'h58;
    send_file();
    // fmt chunk of the wrong size
    start_file();
    add_fmt(FORMAT_PCM, 32'd18, 16'd1, 32'd8000, 16'd8);
    add_data(4);
    seal_file();
    send_file();
    // float format
    start_file();
    add_fmt(FORMAT_FLOAT, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd32);
    add_data(4);
    seal_file();
    send_file();
    // no data chunk
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    seal_file();
    send_file();
    // riff end right after fmt, data chunk beyond it
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(4);
    set_declared(32'd28);
    send_file();
    // data chunk reaching past the riff end
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd1, 32'd8000, 16'd8);
    add_data(4);
    set_declared(32'(file_bytes.size() - 10));
    send_file();
    // cut off inside the payload
    start_file();
    add_fmt(FORMAT_PCM, whp_pkg::FMT_SIZE, 16'd2, 32'd8000, 16'd16);
    add_data(20);
    seal_file();
    truncate_file(file_bytes.size() - 7);
    send_file();
  endtask

  // mostly well-formed files with random content, some damaged, some noise
  task automatic random_file();
    int  r;
    int  n;
    int  pos;
    bit  data_first;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      file_bytes.delete();
      if (r < 4) put32(whp_pkg::TAG_RIFF);
      add_junk($urandom_range(1, 40));
    end else begin
      data_first = ($urandom_range(0, 3) == 0);
      start_file();
      n = $urandom_range(0, 9);
      repeat ((n < 6) ? 0 : (n < 9) ? 1 : 2) add_unknown($urandom_range(0, 12));
      if (data_first && $urandom_range(0, 19) != 0) add_data(pick_payload());
      if ($urandom_range(0, 19) != 0) add_random_fmt();
      if ($urandom_range(0, 19) == 0) add_random_fmt();
      if ($urandom_range(0, 3) == 0) add_unknown($urandom_range(0, 12));
      if (!data_first && $urandom_range(0, 19) != 0) add_data(pick_payload());
      if ($urandom_range(0, 4) == 0) add_unknown($urandom_range(0, 8));
      seal_file();
      n = file_bytes.size();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        pos = $urandom_range(0, n - 1);
        file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
      end else if (r < 18) begin
        truncate_file($urandom_range(1, n - 1));
      end else if (r < 24) begin
        set_declared(32'(n - 8 + $urandom_range(1, 64)));
      end else if (r < 30) begin
        set_declared(32'($urandom_range(0, n - 8)));
      end else if (r < 36) begin
        add_junk($urandom_range(1, 16));
      end else if (r < 38) begin
        set_declared($urandom);
      end
    end
    send_file();
  endtask

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    directed_files();
    while (bytes_streamed < 2000) random_file();
    in_valid <= 1'b0;
    // drain outstanding results, then allow for the divider
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/whp_pkg.sv
hw/rtl/whp_div.sv
hw/rtl/whp_dpath.sv
hw/rtl/whp_ctrl.sv
hw/rtl/wave_header_parser.sv
test/wave_header_parser_tb.sv
